[rtl/sobrgb_pkg.sv]
`default_nettype none
package sobrgb_pkg;

  // Default capacity of the line stores and the row counter.
  localparam int SOB_MAX_WIDTH  = 1024;
  localparam int SOB_MAX_HEIGHT = 4096;

  // Configuration register indexes.
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;

  // Sums of squares at or above this value round to more than 255.
  localparam logic [21:0] CAP_LIMIT = 22'd65281;
  localparam logic [7:0]  MAG_MAX   = 8'd255;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_GRAD,
    S_SQUARE,
    S_ROOT,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic accept;
    logic calc;
    logic grad;
    logic square;
    logic root_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic emit;
    logic root_last;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

[rtl/sobel_edge_rgb_core.sv]
`default_nettype none
// Channel   Direction  Handshake                    Contents
// s_axis    in         s_axis_tvalid/s_axis_tready  one RGB pixel or flush word
// m_axis    out        m_axis_tvalid/m_axis_tready  one gradient magnitude word
// cfg       in         cfg_valid/cfg_ready          image width or height
//
// An input word that produces no result is accepted, then the line store and window are
// updated; one that does also runs the gradient, the squares and an eight-step square
// root one after another, one root bit per cycle, before it finishes.
// Reset is synchronous and active high; it restores width 640 and height 480.
// A result waits in the output register while the next input word is accepted; the
// pipeline only holds in its last step when that register is still full.
module sobel_edge_rgb_core #(
  parameter int MAX_WIDTH  = sobrgb_pkg::SOB_MAX_WIDTH,
  parameter int MAX_HEIGHT = sobrgb_pkg::SOB_MAX_HEIGHT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [23:0] s_axis_tdata,   // in_blue, in_green, in_red
  input  wire logic        s_axis_tuser,   // flush
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // out_blue, out_green, out_red
  output logic             m_axis_tlast,   // frame_last
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [12:0] cfg_data
);
  import sobrgb_pkg::*;

  cmd_t    cmd;
  status_t status;

  // The user must send register writes only while the block is idle (not enforced here); they are always taken.
  assign cfg_ready = 1'b1;

  sobrgb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .status   (status),
    .cmd      (cmd)
  );

  sobrgb_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_axis_tdata),
    .in_flush  (s_axis_tuser),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule
`default_nettype wire

[rtl/sobrgb_ctrl.sv]
`default_nettype none
module sobrgb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sobrgb_pkg::status_t status,
  output sobrgb_pkg::cmd_t       cmd
);
  import sobrgb_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = status.emit ? S_GRAD : S_IDLE;
      end
      S_GRAD: begin
        cmd.grad   = 1'b1;
        state_next = S_SQUARE;
      end
      S_SQUARE: begin
        cmd.square = 1'b1;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        cmd.root_step = 1'b1;
        if (status.root_last) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

[rtl/sobrgb_dp.sv]
`default_nettype none
module sobrgb_dp #(
  parameter int MAX_WIDTH  = sobrgb_pkg::SOB_MAX_WIDTH,
  parameter int MAX_HEIGHT = sobrgb_pkg::SOB_MAX_HEIGHT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire sobrgb_pkg::cmd_t    cmd,
  output sobrgb_pkg::status_t      status,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_index,
  input  wire logic [12:0]         cfg_data,
  input  wire logic [23:0]         in_data,
  input  wire logic                in_flush,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic [23:0]              out_data,
  output logic                     out_last
);
  import sobrgb_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int XW = (CW + 1 > 11) ? CW + 1 : 11;
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);
  localparam int YW = (RW > 13) ? RW : 13;

  logic [10:0]     image_width;
  logic [12:0]     image_height;
  logic [CW:0]     eff_w;
  logic [HW-1:0]   eff_h;

  logic [CW-1:0]   column_count;
  logic [RW-1:0]   row_count;
  logic [CW-1:0]   c_use;
  logic [CW-1:0]   cur_c;
  logic [RW-1:0]   cur_r;
  logic [23:0]     pix;

  // Each line store word holds the row above (low half) and two above (high).
  logic [47:0]     line_mem [MAX_WIDTH];
  logic [47:0]     rd_word;

  logic [23:0]     window [9];
  logic            mask_l, mask_r, mask_t, mask_b, last_pix;

  logic signed [11:0] gx [3];
  logic signed [11:0] gy [3];
  logic [21:0]     sumsq [3];
  logic [7:0]      root [3];
  logic [7:0]      bitm;

  // Position logic for the item being finished.
  logic [CW:0]     c_inc;
  logic [RW:0]     r_inc;
  logic [RW:0]     h_plus1;
  logic            pos_valid;
  logic [RW-1:0]   crow;
  logic [CW-1:0]   cc;
  logic            emit;

  always_comb begin
    if (image_width == '0) begin
      eff_w = (CW + 1)'(1);
    end else if (XW'(image_width) > XW'(MAX_WIDTH)) begin
      eff_w = (CW + 1)'(MAX_WIDTH);
    end else begin
      eff_w = (CW + 1)'(image_width);
    end
    if (image_height == '0) begin
      eff_h = HW'(1);
    end else if (YW'(image_height) > YW'(MAX_HEIGHT)) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(image_height);
    end
  end

  assign c_use = ({1'b0, column_count} >= eff_w) ? '0 : column_count;

  always_comb begin
    h_plus1 = (RW + 1)'(eff_h) + 1'b1;
    c_inc   = {1'b0, cur_c} + 1'b1;
    r_inc   = {1'b0, cur_r};
    if (c_inc >= eff_w) begin
      r_inc = r_inc + 1'b1;
    end
    if (r_inc > h_plus1) begin
      r_inc = h_plus1;
    end
    if (cur_c != '0) begin
      pos_valid = cur_r >= RW'(1);
      crow      = cur_r - RW'(1);
      cc        = cur_c - CW'(1);
    end else begin
      pos_valid = cur_r >= RW'(2);
      crow      = cur_r - RW'(2);
      cc        = CW'(eff_w - 1'b1);
    end
    emit = pos_valid && ((RW + 1)'(crow) < (RW + 1)'(eff_h));
  end

  assign status.emit      = emit;
  assign status.root_last = bitm[0];
  assign status.out_free  = !out_valid || out_ready;

  // Configuration and frame counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      column_count <= '0;
      row_count    <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data[10:0];
        REG_HEIGHT: image_height <= cfg_data;
        default:    image_height <= cfg_data;
      endcase
      column_count <= '0;
      row_count    <= '0;
    end else if (cmd.calc) begin
      if (emit && (crow == RW'(eff_h - 1'b1)) && ((CW + 1)'(cc) == eff_w - 1'b1)) begin
        column_count <= '0;
        row_count    <= '0;
      end else begin
        column_count <= (c_inc >= eff_w) ? '0 : c_inc[CW-1:0];
        row_count    <= r_inc[RW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pix     <= in_flush ? '0 : in_data;
      cur_c   <= c_use;
      cur_r   <= row_count;
      rd_word <= line_mem[c_use];
    end
    if (cmd.calc) begin
      line_mem[cur_c] <= {rd_word[23:0], pix};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        window[i] <= '0;
      end
    end else if (cmd.calc) begin
      for (int m = 0; m < 3; m++) begin
        window[m*3]   <= window[m*3+1];
        window[m*3+1] <= window[m*3+2];
      end
      window[2] <= rd_word[47:24];
      window[5] <= rd_word[23:0];
      window[8] <= pix;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      mask_l   <= cc == '0;
      mask_r   <= (CW + 1)'(cc) == eff_w - 1'b1;
      mask_t   <= crow == '0;
      mask_b   <= crow == RW'(eff_h - 1'b1);
      last_pix <= (crow == RW'(eff_h - 1'b1)) && ((CW + 1)'(cc) == eff_w - 1'b1);
    end
  end

  // Gradients on the border-masked window.
  logic signed [11:0] v [3][9];
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int i = 0; i < 9; i++) begin
        v[ch][i] = {4'b0, window[i][ch*8 +: 8]};
        if ((mask_l && (i % 3 == 0)) || (mask_r && (i % 3 == 2)) ||
            (mask_t && (i < 3)) || (mask_b && (i > 5))) begin
          v[ch][i] = '0;
        end
      end
    end
  end

  // Squares are formed at full width; a gradient reaches 1020 in magnitude.
  logic signed [23:0] sqx [3];
  logic signed [23:0] sqy [3];
  logic [7:0]         trial [3];
  logic [15:0]        trial_sq [3];
  logic [15:0]        root_sq [3];
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sqx[ch]      = gx[ch] * gx[ch];
      sqy[ch]      = gy[ch] * gy[ch];
      trial[ch]    = root[ch] | bitm;
      trial_sq[ch] = trial[ch] * trial[ch];
      root_sq[ch]  = root[ch] * root[ch];
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (cmd.grad) begin
        gx[ch] <= v[ch][2] - v[ch][0] + (v[ch][5] <<< 1) - (v[ch][3] <<< 1)
                + v[ch][8] - v[ch][6];
        gy[ch] <= v[ch][6] - v[ch][0] + (v[ch][7] <<< 1) - (v[ch][1] <<< 1)
                + v[ch][8] - v[ch][2];
      end
      if (cmd.square) begin
        sumsq[ch] <= sqx[ch][21:0] + sqy[ch][21:0];
        root[ch]  <= '0;
      end else if (cmd.root_step) begin
        if ({6'b0, trial_sq[ch]} <= sumsq[ch]) begin
          root[ch] <= trial[ch];
        end
      end
    end
    if (cmd.square) begin
      bitm <= 8'h80;
    end else if (cmd.root_step) begin
      bitm <= bitm >> 1;
    end
  end

  // Round to nearest: step up when the remainder exceeds the root.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      for (int ch = 0; ch < 3; ch++) begin
        if (sumsq[ch] >= CAP_LIMIT) begin
          out_data[ch*8 +: 8] <= MAG_MAX;
        end else if (sumsq[ch] - {6'b0, root_sq[ch]} > {14'b0, root[ch]}) begin
          out_data[ch*8 +: 8] <= root[ch] + 1'b1;
        end else begin
          out_data[ch*8 +: 8] <= root[ch];
        end
      end
      out_last <= last_pix;
    end
  end

endmodule
`default_nettype wire
